FILE: design/tpba_pkg.sv
package tpba_pkg;

    // Default build of the unit
    localparam int COORD_BITS_DEF    = 24;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Offsets are scaled so that their magnitude sits just below 2^SCALE_POS
    localparam int SCALE_POS = 60;
    // CORDIC x/y datapath: 2^60 times sqrt(2) times the gain of about 1.65 plus sign
    localparam int CORDIC_W  = 63;
    // Angle accumulator in 2^-32 turn units, signed
    localparam int ACC_W     = 34;
    localparam logic [ACC_W-1:0] ACC_QUARTER = ACC_W'(64'd1 << 30);

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_A_X = 2'd0,
        CFG_REF_A_Y = 2'd1,
        CFG_REF_B_X = 2'd2,
        CFG_REF_B_Y = 2'd3
    } t_cfg_reg;

    // atan(2^-i) in 2^-32 turn units, truncated
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000000;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: design/two_point_bearing_angles_unit.sv
// Pipeline registers from request accept to result valid, in order:
//   offset, magnitude, each CORDIC iteration, round, quadrant, swept angle.
// Throughput: one request per cycle; the whole pipeline advances together and holds
//   when the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits and the reference points to 0.
module two_point_bearing_angles_unit #(
    parameter int COORD_BITS    = tpba_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS    = tpba_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = tpba_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // configuration write port
    input  logic                                        i_cfg_we,
    input  logic [tpba_pkg::CFG_IDX_W-1:0]              i_cfg_idx,
    input  logic [COORD_BITS-1:0]                       i_cfg_wdata,
    // input stream
    input  logic                                        i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // tdata: pos_x, pos_y (low bits first), zero padded
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]           i_s_axis_tdata,
    // output stream
    output logic                                        o_m_axis_tvalid,
    input  logic                                        i_m_axis_tready,
    // tdata: bearing_a, bearing_b, swept_angle (low bits first), zero padded
    output logic [((3*ANGLE_BITS+1+7)/8)*8-1:0]         o_m_axis_tdata
);

    localparam int DW         = COORD_BITS + 1;
    localparam int CW         = tpba_pkg::CORDIC_W;
    localparam int ZW         = tpba_pkg::ACC_W;
    localparam int PRE_SHIFT  = tpba_pkg::SCALE_POS - COORD_BITS;
    localparam int NS         = CORDIC_STAGES;
    localparam int DEPTH      = CORDIC_STAGES + 5;
    localparam int OUT_W      = ((3*ANGLE_BITS+1+7)/8)*8;
    localparam int RND_SHIFT  = 32 - ANGLE_BITS;
    localparam logic [31:0] RND_HALF = 32'd1 << (RND_SHIFT - 1);

    localparam logic [ANGLE_BITS-1:0] A_ZERO    = '0;
    localparam logic [ANGLE_BITS-1:0] A_QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] A_HALF    = {2'b10, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] A_THREEQ  = {2'b11, {(ANGLE_BITS-2){1'b0}}};

    // per-reference side info that rides along the CORDIC pipeline
    typedef struct packed {
        logic                  spec;
        logic [ANGLE_BITS-1:0] sval;
        logic                  neg_x;
        logic                  neg_y;
    } t_side;

    logic signed [COORD_BITS-1:0] r_ref_ax, r_ref_ay, r_ref_bx, r_ref_by;
    logic [DEPTH-1:0]             r_vld;
    logic                         en;

    logic signed [COORD_BITS-1:0] pos_x, pos_y;
    logic signed [DW-1:0]         n_dx [2];
    logic signed [DW-1:0]         n_dy [2];
    logic signed [DW-1:0]         r_dx [2];
    logic signed [DW-1:0]         r_dy [2];

    logic signed [CW-1:0]         n_cx0 [2];
    logic signed [CW-1:0]         n_cy0 [2];
    t_side                        n_side0 [2];

    logic signed [CW-1:0]         r_cx [NS+1][2];
    logic signed [CW-1:0]         r_cy [NS+1][2];
    logic signed [ZW-1:0]         r_cz [NS+1][2];
    logic signed [CW-1:0]         n_cx [NS][2];
    logic signed [CW-1:0]         n_cy [NS][2];
    logic signed [ZW-1:0]         n_cz [NS][2];
    t_side                        r_side [NS+2][2];

    logic [ANGLE_BITS-1:0]        n_q [2];
    logic [ANGLE_BITS-1:0]        r_q [2];
    logic [ANGLE_BITS-1:0]        n_bear [2];
    logic [ANGLE_BITS-1:0]        r_bear [2];
    logic [ANGLE_BITS:0]          n_swept;
    logic [ANGLE_BITS:0]          r_swept;
    logic [ANGLE_BITS-1:0]        r_out_a, r_out_b;

    // advance the whole pipeline unless a finished result is held back
    assign en              = !r_vld[DEPTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[DEPTH-1];
    assign o_m_axis_tdata  = OUT_W'({r_swept, r_out_b, r_out_a});

    assign pos_x = i_s_axis_tdata[COORD_BITS-1:0];
    assign pos_y = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    // reference point registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_ax <= '0;
            r_ref_ay <= '0;
            r_ref_bx <= '0;
            r_ref_by <= '0;
        end else if (i_cfg_we) begin
            unique case (tpba_pkg::t_cfg_reg'(i_cfg_idx))
                tpba_pkg::CFG_REF_A_X: r_ref_ax <= i_cfg_wdata;
                tpba_pkg::CFG_REF_A_Y: r_ref_ay <= i_cfg_wdata;
                tpba_pkg::CFG_REF_B_X: r_ref_bx <= i_cfg_wdata;
                tpba_pkg::CFG_REF_B_Y: r_ref_by <= i_cfg_wdata;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    // form offsets from the position to each reference
    always_comb begin
        n_dx[0] = {r_ref_ax[COORD_BITS-1], r_ref_ax} - {pos_x[COORD_BITS-1], pos_x};
        n_dy[0] = {r_ref_ay[COORD_BITS-1], r_ref_ay} - {pos_y[COORD_BITS-1], pos_y};
        n_dx[1] = {r_ref_bx[COORD_BITS-1], r_ref_bx} - {pos_x[COORD_BITS-1], pos_x};
        n_dy[1] = {r_ref_by[COORD_BITS-1], r_ref_by} - {pos_y[COORD_BITS-1], pos_y};
    end

    // take magnitudes, scale up, and resolve the axis cases
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            logic [DW-1:0] ax, ay;
            logic          dy_pos, dx_pos;
            ax     = r_dx[l][DW-1] ? DW'(-r_dx[l]) : DW'(r_dx[l]);
            ay     = r_dy[l][DW-1] ? DW'(-r_dy[l]) : DW'(r_dy[l]);
            dx_pos = !r_dx[l][DW-1] && (r_dx[l] != '0);
            dy_pos = !r_dy[l][DW-1] && (r_dy[l] != '0);
            n_cx0[l] = CW'(ax) << PRE_SHIFT;
            n_cy0[l] = CW'(ay) << PRE_SHIFT;
            n_side0[l].neg_x = r_dx[l][DW-1];
            n_side0[l].neg_y = r_dy[l][DW-1];
            n_side0[l].spec  = (r_dx[l] == '0) || (r_dy[l] == '0);
            if (r_dx[l] == '0) begin
                n_side0[l].sval = dy_pos ? A_QUARTER : A_THREEQ;
            end else begin
                n_side0[l].sval = dx_pos ? A_ZERO : A_HALF;
            end
        end
    end

    // one CORDIC vectoring iteration per stage
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < 2; l++) begin
                if (!r_cy[k][l][CW-1]) begin
                    n_cx[k][l] = r_cx[k][l] + (r_cy[k][l] >>> k);
                    n_cy[k][l] = r_cy[k][l] - (r_cx[k][l] >>> k);
                    n_cz[k][l] = r_cz[k][l] + ZW'(tpba_pkg::atan_entry(5'(k)));
                end else begin
                    n_cx[k][l] = r_cx[k][l] - (r_cy[k][l] >>> k);
                    n_cy[k][l] = r_cy[k][l] + (r_cx[k][l] >>> k);
                    n_cz[k][l] = r_cz[k][l] - ZW'(tpba_pkg::atan_entry(5'(k)));
                end
            end
        end
    end

    // clamp the angle to a quarter turn and round half up
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            logic [30:0] zc;
            logic [31:0] zs;
            if (r_cz[NS][l][ZW-1]) begin
                zc = '0;
            end else if (r_cz[NS][l] > $signed(tpba_pkg::ACC_QUARTER)) begin
                zc = 31'(tpba_pkg::ACC_QUARTER);
            end else begin
                zc = r_cz[NS][l][30:0];
            end
            zs     = {1'b0, zc} + RND_HALF;
            n_q[l] = zs[31:RND_SHIFT];
        end
    end

    // place the first-quadrant angle into its quadrant
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            t_side s;
            s = r_side[NS+1][l];
            if (s.spec) begin
                n_bear[l] = s.sval;
            end else begin
                unique case ({s.neg_x, s.neg_y})
                    2'b00: n_bear[l] = r_q[l];
                    2'b10: n_bear[l] = A_HALF - r_q[l];
                    2'b11: n_bear[l] = A_HALF + r_q[l];
                    2'b01: n_bear[l] = A_ZERO - r_q[l];
                endcase
            end
        end
    end

    // swept angle from A to B, a full turn when equal
    always_comb begin
        if (r_bear[1] > r_bear[0]) begin
            n_swept = {1'b0, r_bear[1]} - {1'b0, r_bear[0]};
        end else begin
            n_swept = {1'b1, {ANGLE_BITS{1'b0}}} - ({1'b0, r_bear[0]} - {1'b0, r_bear[1]});
        end
    end

    // datapath registers: hold on stall
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                r_dx[l]      <= n_dx[l];
                r_dy[l]      <= n_dy[l];
                r_cx[0][l]   <= n_cx0[l];
                r_cy[0][l]   <= n_cy0[l];
                r_cz[0][l]   <= '0;
                r_side[0][l] <= n_side0[l];
                for (int k = 0; k < NS; k++) begin
                    r_cx[k+1][l]   <= n_cx[k][l];
                    r_cy[k+1][l]   <= n_cy[k][l];
                    r_cz[k+1][l]   <= n_cz[k][l];
                    r_side[k+1][l] <= r_side[k][l];
                end
                r_side[NS+1][l] <= r_side[NS][l];
                r_q[l]          <= n_q[l];
                r_bear[l]       <= n_bear[l];
            end
            r_out_a <= r_bear[0];
            r_out_b <= r_bear[1];
            r_swept <= n_swept;
        end
    end

endmodule
